// ===== design/jcdc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_pkg
// Shared types and constants of the Julian day / calendar converter.
// ============================================================================
package jcdc_pkg;

  localparam int unsigned LAT = 8;

  typedef enum logic {
    CMD_TO_CAL = 1'b0,
    CMD_TO_DC  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [63:0] day_time;
    logic signed [17:0] year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [4:0]         hour_in;
    logic [5:0]         minute_in;
    logic [25:0]        second_us_in;
    logic signed [11:0] zone_minutes;
  } item_t;

  typedef struct packed {
    logic signed [17:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [25:0]        second_us;
    logic               oor;
  } cal_res_t;

  typedef struct packed {
    logic signed [63:0] day_time;
    logic               oor;
  } dc_res_t;

  // microseconds per day scaled by 2^-11
  localparam logic [25:0] US_DAY_SCALED = 26'd42187500;
  localparam logic [25:0] US_PER_MIN    = 26'd60000000;
  localparam logic [25:0] US_ROUND_EDGE = 26'd59999500;
  localparam logic [36:0] US_DAY_CARRY  = 37'd86399999500;
  localparam logic [34:0] JD_J2000      = 35'd2451545;
  localparam logic [25:0] JD_LAST_JUL   = 26'd2299160;
  localparam logic [23:0] DC_DIV        = 24'd10546875;
  localparam logic [23:0] DC_HALF_Q     = 24'd5273437;
  localparam logic [16:0] DC_OFS_Q      = 17'd11700;

endpackage

// ===== design/jcdc_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_in_if
// Input channel: valid/ready handshake with one conversion request.
// ============================================================================
interface jcdc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [63:0] day_time;
  logic signed [17:0] year_in;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic [4:0]         hour_in;
  logic [5:0]         minute_in;
  logic [25:0]        second_us_in;
  logic signed [11:0] zone_minutes;

  modport source (output valid, cmd, day_time, year_in, month_in, day_in, hour_in,
                  minute_in, second_us_in, zone_minutes, input ready);
  modport sink (input valid, cmd, day_time, year_in, month_in, day_in, hour_in,
                minute_in, second_us_in, zone_minutes, output ready);
endinterface

// ===== design/jcdc_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_out_if
// Result channel: valid/ready handshake with one conversion result.
// ============================================================================
interface jcdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] day_time_out;
  logic signed [17:0] year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic [4:0]         hour_out;
  logic [5:0]         minute_out;
  logic [25:0]        second_us_out;
  logic               out_of_range;

  modport source (output valid, day_time_out, year_out, month_out, day_out, hour_out,
                  minute_out, second_us_out, out_of_range, input ready);
  modport sink (input valid, day_time_out, year_out, month_out, day_out, hour_out,
                minute_out, second_us_out, out_of_range, output ready);
endinterface

// ===== design/jcdc_to_cal.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_to_cal
// Eight-stage datapath: Q32.32 day count to calendar date and time of day.
// ============================================================================
module jcdc_to_cal import jcdc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] day_time,
  output cal_res_t    res_o
);

  // stage 1
  logic [32:0] f1;
  logic [57:0] p1;
  logic [33:0] d1_r, d1_nxt;
  logic [36:0] tus1_r, tus1_nxt;
  // stage 2
  logic        carry2;
  logic [34:0] j2;
  logic [58:0] p2;
  logic [10:0] mq2_r, mq2_nxt;
  logic [36:0] tus2_r;
  logic [25:0] jc2_r, jc2_nxt;
  logic        neg2_r, neg2_nxt, big2_r, big2_nxt;
  // stage 3
  logic [36:0] r3;
  logic [27:0] g3_nxt, g3_r;
  logic [55:0] p3;
  logic [10:0] ga3_r, ga3_nxt;
  logic [10:0] mins3_r, mins3_nxt;
  logic [25:0] us3_r, us3_nxt;
  logic [25:0] jc3_r;
  logic        greg3_r, greg3_nxt, neg3_r, big3_r;
  // stage 4
  logic [27:0] gr4;
  logic [11:0] ga4;
  logic [13:0] b4;
  logic [26:0] jj4;
  logic [28:0] n4_r, n4_nxt;
  logic [10:0] mins4_r, mins4_nxt;
  logic [25:0] us4_r, us4_nxt;
  logic        neg4_r, big4_r;
  // stage 5
  logic [21:0] hp5;
  logic [4:0]  hr5_r, hr5_nxt;
  logic [5:0]  mn5_r, mn5_nxt;
  logic [25:0] us5_r;
  logic [58:0] py5;
  logic [18:0] yq5_r, yq5_nxt;
  logic [28:0] n45_r;
  logic        neg5_r, big5_r;
  // stage 6
  logic [28:0] ry6;
  logic [19:0] yqc6;
  logic [10:0] rem6, rem26;
  logic [19:0] yr6_r, yr6_nxt;
  logic [11:0] n10_6_r, n10_6_nxt;
  logic [4:0]  hr6_r;
  logic [5:0]  mn6_r;
  logic [25:0] us6_r;
  logic        oor6_r, oor6_nxt;
  // stage 7
  logic [21:0] pq7;
  logic [3:0]  mq7_r, mq7_nxt;
  logic [11:0] r7;
  logic [8:0]  d10_7_r, d10_7_nxt;
  logic [19:0] yr7_r;
  logic [4:0]  hr7_r;
  logic [5:0]  mn7_r;
  logic [25:0] us7_r;
  logic        oor7_r;
  // stage 8
  logic [16:0] pd8;
  logic [4:0]  qm8;
  cal_res_t    res_r, res_nxt;

  always_comb begin
    f1       = {1'b0, day_time[31:0]} + 33'h0_8000_0000;
    d1_nxt   = {{2{day_time[63]}}, day_time[63:32]} + {33'd0, f1[32]};
    p1       = {26'd0, f1[31:0]} * {32'd0, US_DAY_SCALED};
    tus1_nxt = p1[57:21];
  end

  always_comb begin
    carry2   = (tus1_r >= US_DAY_CARRY);
    j2       = {d1_r[33], d1_r} + JD_J2000 + {34'd0, carry2};
    neg2_nxt = j2[34];
    big2_nxt = !j2[34] && (j2[33:26] != 8'd0);
    jc2_nxt  = j2[25:0];
    p2       = {30'd0, tus1_r[36:8]} * {29'd0, 30'd600479950};
    mq2_nxt  = p2[57:47];
  end

  always_comb begin
    r3 = tus2_r - ({26'd0, mq2_r} * {11'd0, US_PER_MIN});
    if (r3 >= {11'd0, US_PER_MIN}) begin
      mins3_nxt = mq2_r + 11'd1;
      us3_nxt   = r3[25:0] - US_PER_MIN;
    end else begin
      mins3_nxt = mq2_r;
      us3_nxt   = r3[25:0];
    end
    g3_nxt    = {jc2_r, 2'b00} - 28'd17918;
    p3        = {28'd0, g3_nxt} * {28'd0, 28'd240828847};
    ga3_nxt   = p3[55:45];
    greg3_nxt = (jc2_r > JD_LAST_JUL);
  end

  always_comb begin
    if (us3_r >= US_ROUND_EDGE) begin
      us4_nxt   = 26'd0;
      mins4_nxt = (mins3_r == 11'd1439) ? 11'd0 : mins3_r + 11'd1;
    end else begin
      us4_nxt   = us3_r;
      mins4_nxt = mins3_r;
    end
    gr4 = g3_r - ({17'd0, ga3_r} * 28'd146097);
    ga4 = (gr4 >= 28'd146097) ? {1'b0, ga3_r} + 12'd1 : {1'b0, ga3_r};
    b4  = ({2'b00, ga4} + {1'b0, ga4, 1'b0} + 14'd2) >> 2;
    jj4 = {1'b0, jc3_r} + {13'd0, b4} - 27'd37;
    n4_nxt = greg3_r ? {jj4, 2'b00} : {1'b0, jc3_r, 2'b00};
  end

  always_comb begin
    hp5     = mins4_r * 11'd1093;
    hr5_nxt = hp5[20:16];
    mn5_nxt = 6'(mins4_r - {6'd0, hr5_nxt} * 11'd60);
    py5     = {30'd0, n4_r} * {29'd0, 30'd752574693};
    yq5_nxt = py5[58:40];
  end

  always_comb begin
    ry6 = n45_r - ({10'd0, yq5_r} * 29'd1461);
    if (ry6 >= 29'd1461) begin
      yqc6 = {1'b0, yq5_r} + 20'd1;
      rem6 = 11'(ry6 - 29'd1461);
    end else begin
      yqc6 = {1'b0, yq5_r};
      rem6 = ry6[10:0];
    end
    yr6_nxt   = yqc6 - 20'd4712;
    rem26     = (rem6 >= 11'd237) ? rem6 - 11'd237 : rem6 + 11'd1224;
    n10_6_nxt = {3'd0, rem26[10:2]} * 12'd10 + 12'd5;
    oor6_nxt  = neg5_r || big5_r || ($signed(yr6_nxt) > 20'sd99999);
  end

  always_comb begin
    pq7 = n10_6_r * 10'd856;
    r7  = n10_6_r - {8'd0, pq7[21:18]} * 12'd306;
    if (r7 >= 12'd306) begin
      mq7_nxt   = pq7[21:18] + 4'd1;
      d10_7_nxt = 9'(r7 - 12'd306);
    end else begin
      mq7_nxt   = pq7[21:18];
      d10_7_nxt = r7[8:0];
    end
  end

  always_comb begin
    pd8 = d10_7_r * 8'd205;
    qm8 = {1'b0, mq7_r} + 5'd2;
    res_nxt = '0;
    if (oor7_r) begin
      res_nxt.oor = 1'b1;
    end else begin
      res_nxt.year      = yr7_r[17:0];
      res_nxt.month     = (qm8 >= 5'd12) ? 4'(qm8 - 5'd11) : 4'(qm8 + 5'd1);
      res_nxt.day       = pd8[15:11] + 5'd1;
      res_nxt.hour      = hr7_r;
      res_nxt.minute    = mn7_r;
      res_nxt.second_us = us7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= d1_nxt;
      tus1_r  <= tus1_nxt;
      mq2_r   <= mq2_nxt;
      tus2_r  <= tus1_r;
      jc2_r   <= jc2_nxt;
      neg2_r  <= neg2_nxt;
      big2_r  <= big2_nxt;
      g3_r    <= g3_nxt;
      ga3_r   <= ga3_nxt;
      mins3_r <= mins3_nxt;
      us3_r   <= us3_nxt;
      jc3_r   <= jc2_r;
      greg3_r <= greg3_nxt;
      neg3_r  <= neg2_r;
      big3_r  <= big2_r;
      n4_r    <= n4_nxt;
      mins4_r <= mins4_nxt;
      us4_r   <= us4_nxt;
      neg4_r  <= neg3_r;
      big4_r  <= big3_r;
      hr5_r   <= hr5_nxt;
      mn5_r   <= mn5_nxt;
      us5_r   <= us4_r;
      yq5_r   <= yq5_nxt;
      n45_r   <= n4_r;
      neg5_r  <= neg4_r;
      big5_r  <= big4_r;
      yr6_r   <= yr6_nxt;
      n10_6_r <= n10_6_nxt;
      hr6_r   <= hr5_r;
      mn6_r   <= mn5_r;
      us6_r   <= us5_r;
      oor6_r  <= oor6_nxt;
      mq7_r   <= mq7_nxt;
      d10_7_r <= d10_7_nxt;
      yr7_r   <= yr6_r;
      hr7_r   <= hr6_r;
      mn7_r   <= mn6_r;
      us7_r   <= us6_r;
      oor7_r  <= oor6_r;
      res_r   <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== design/jcdc_to_dc.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_to_dc
// Eight-stage datapath: calendar date, local time and zone to Q32.32 days.
// ============================================================================
module jcdc_to_dc import jcdc_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  item_t    item_i,
  output dc_res_t  res_o
);

  // stage 1
  logic signed [18:0] y1;
  logic signed [5:0]  m1;
  logic signed [18:0] yy1_r, yy1_nxt;
  logic [3:0]         mo1_r, mo1_nxt;
  logic [4:0]         d1_r;
  logic [25:0]        us1_r;
  logic signed [13:0] mins1_r, mins1_nxt;
  logic               yoor1_r, yoor1_nxt;
  // stage 2
  logic signed [39:0] tp2;
  logic signed [31:0] pj2, jda2;
  logic [24:0]        mt2;
  logic [16:0]        yo2;
  logic [34:0]        py2;
  logic [38:0]        tp2_r;
  logic signed [31:0] jd2_r, jd2_nxt;
  logic signed [11:0] c2_r, c2_nxt;
  logic               yoor2_r;
  // stage 3
  logic [55:0]        pc3;
  logic signed [13:0] c33;
  logic [15:0]        cq3_r, cq3_nxt;
  logic [38:0]        tp3_r;
  logic signed [31:0] jd3_r, jd3_nxt;
  logic               yoor3_r;
  // stage 4
  logic [38:0]        b4;
  logic [16:0]        a4_r, a4_nxt;
  logic [23:0]        bb4_r, bb4_nxt;
  logic signed [31:0] jd4_r;
  logic               yoor4_r;
  // stage 5
  logic [42:0]        x5;
  logic [63:0]        pq5;
  logic [42:0]        x5_r;
  logic [19:0]        q5_r;
  logic [16:0]        a5_r;
  logic signed [31:0] jd5_r;
  logic               yoor5_r;
  // stage 6
  logic [42:0]        r6;
  logic [19:0]        q6_r, q6_nxt;
  logic [16:0]        a6_r;
  logic signed [31:0] jd6_r;
  logic               yoor6_r;
  // stage 7
  logic signed [17:0] as7;
  logic [63:0]        tot7_r, tot7_nxt;
  logic               yoor7_r;
  dc_res_t            res_r, res_nxt;

  always_comb begin
    y1        = {item_i.year_in[17], item_i.year_in};
    yoor1_nxt = (y1 < -19'sd4712) || (y1 > 19'sd99999);
    m1        = $signed({2'b00, item_i.month_in}) - 6'sd3;
    if (m1 < 6'sd0) begin
      m1 = m1 + 6'sd12;
      y1 = y1 - 19'sd1;
    end
    mo1_nxt   = m1[3:0];
    yy1_nxt   = y1 + 19'sd4712;
    mins1_nxt = $signed({8'd0, item_i.minute_in})
              + $signed({1'b0, {8'd0, item_i.hour_in} * 13'd60})
              - $signed({{2{item_i.zone_minutes[11]}}, item_i.zone_minutes});
  end

  always_comb begin
    tp2  = $signed({14'd0, us1_r}) + $signed({{26{mins1_r[13]}}, mins1_r}) * 40'sd60000000
         + 40'sd123398437500;
    pj2  = $signed({{13{yy1_r[18]}}, yy1_r}) * 32'sd1461;
    jda2 = (pj2 >>> 2) - 32'sd2451487;
    mt2  = ({21'd0, mo1_r} * 25'd306 + 25'd5) * 25'd6554;
    jd2_nxt = jda2 + $signed({23'd0, mt2[24:16]}) + $signed({27'd0, d1_r});
    yo2  = 17'(yy1_r + 19'sd88);
    py2  = {18'd0, yo2} * {17'd0, 18'd167773};
    c2_nxt = $signed({1'b0, py2[34:24]}) - 12'sd59;
  end

  always_comb begin
    pc3     = {17'd0, tp2_r} * {39'd0, 17'd104249};
    cq3_nxt = pc3[55:40];
    c33     = ($signed({{2{c2_r[11]}}, c2_r}) * 14'sd3) >>> 2;
    if (jd2_r > -32'sd152386) begin
      jd3_nxt = jd2_r - ($signed({{18{c33[13]}}, c33}) + 32'sd7);
    end else begin
      jd3_nxt = jd2_r;
    end
  end

  always_comb begin
    b4 = tp3_r - ({23'd0, cq3_r} * {15'd0, DC_DIV});
    if (b4 >= {15'd0, DC_DIV}) begin
      a4_nxt  = {1'b0, cq3_r} + 17'd1;
      bb4_nxt = 24'(b4 - {15'd0, DC_DIV});
    end else begin
      a4_nxt  = {1'b0, cq3_r};
      bb4_nxt = b4[23:0];
    end
  end

  always_comb begin
    x5  = {bb4_r, 19'd0} + {19'd0, DC_HALF_Q};
    pq5 = {21'd0, x5} * {43'd0, 21'd1667999};
  end

  always_comb begin
    r6     = x5_r - ({23'd0, q5_r} * {19'd0, DC_DIV});
    q6_nxt = (r6 >= {19'd0, DC_DIV}) ? q5_r + 20'd1 : q5_r;
  end

  always_comb begin
    as7      = $signed({1'b0, a6_r}) - $signed({1'b0, DC_OFS_Q});
    tot7_nxt = {jd6_r, 32'd0} + 64'h0000_0000_8000_0000
             + ({{46{as7[17]}}, as7} << 19) + {44'd0, q6_r};
  end

  always_comb begin
    res_nxt = '0;
    if (yoor7_r) begin
      res_nxt.oor = 1'b1;
    end else begin
      res_nxt.day_time = tot7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yy1_r   <= yy1_nxt;
      mo1_r   <= mo1_nxt;
      d1_r    <= item_i.day_in;
      us1_r   <= item_i.second_us_in;
      mins1_r <= mins1_nxt;
      yoor1_r <= yoor1_nxt;
      tp2_r   <= tp2[38:0];
      jd2_r   <= jd2_nxt;
      c2_r    <= c2_nxt;
      yoor2_r <= yoor1_r;
      cq3_r   <= cq3_nxt;
      tp3_r   <= tp2_r;
      jd3_r   <= jd3_nxt;
      yoor3_r <= yoor2_r;
      a4_r    <= a4_nxt;
      bb4_r   <= bb4_nxt;
      jd4_r   <= jd3_r;
      yoor4_r <= yoor3_r;
      x5_r    <= x5;
      q5_r    <= pq5[63:44];
      a5_r    <= a4_r;
      jd5_r   <= jd4_r;
      yoor5_r <= yoor4_r;
      q6_r    <= q6_nxt;
      a6_r    <= a5_r;
      jd6_r   <= jd5_r;
      yoor6_r <= yoor5_r;
      tot7_r  <= tot7_nxt;
      yoor7_r <= yoor6_r;
      res_r   <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== design/julian_calendar_date_converter_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// julian_calendar_date_converter_core
// Converts Q32.32 day counts since 2000-01-01 noon to calendar date and time
// and back, one transfer per cycle while the result channel does not stall.
// ============================================================================
// Both conversion directions run side by side in an eight-stage pipeline that
// accepts one item per clock while the result channel does not stall. Stages
// hold their contents while the result channel stalls, and in_if.ready is low
// only while a finished result waits at the output. The
// calendar path splits the day fraction into hour, minute and microseconds,
// rounds to the next minute within 500 us of it, and derives the date with the
// Julian calendar up to 1582-10-04 and the Gregorian calendar after it.
// Fields that do not belong to the chosen direction read zero; out_of_range
// zeroes all other fields.
// ============================================================================
module julian_calendar_date_converter_core import jcdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  jcdc_in_if.sink     in_if,
  jcdc_out_if.source  out_if
);

  logic           en;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [LAT-1:0] cmd_r, cmd_nxt;
  item_t          item;
  cal_res_t       cal_res;
  dc_res_t        dc_res;

  assign en = !vld_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;

  always_comb begin
    item.cmd          = in_if.cmd;
    item.day_time     = in_if.day_time;
    item.year_in      = in_if.year_in;
    item.month_in     = in_if.month_in;
    item.day_in       = in_if.day_in;
    item.hour_in      = in_if.hour_in;
    item.minute_in    = in_if.minute_in;
    item.second_us_in = in_if.second_us_in;
    item.zone_minutes = in_if.zone_minutes;
    vld_nxt = {vld_r[LAT-2:0], in_if.valid};
    cmd_nxt = {cmd_r[LAT-2:0], in_if.cmd};
  end

  jcdc_to_cal u_to_cal (
    .clk      (clk),
    .en       (en),
    .day_time (item.day_time),
    .res_o    (cal_res)
  );

  jcdc_to_dc u_to_dc (
    .clk    (clk),
    .en     (en),
    .item_i (item),
    .res_o  (dc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= cmd_nxt;
    end
  end

  always_comb begin
    out_if.valid         = vld_r[LAT-1];
    out_if.day_time_out  = '0;
    out_if.year_out      = '0;
    out_if.month_out     = '0;
    out_if.day_out       = '0;
    out_if.hour_out      = '0;
    out_if.minute_out    = '0;
    out_if.second_us_out = '0;
    out_if.out_of_range  = 1'b0;
    unique case (cmd_t'(cmd_r[LAT-1]))
      CMD_TO_CAL: begin
        out_if.year_out      = cal_res.year;
        out_if.month_out     = cal_res.month;
        out_if.day_out       = cal_res.day;
        out_if.hour_out      = cal_res.hour;
        out_if.minute_out    = cal_res.minute;
        out_if.second_us_out = cal_res.second_us;
        out_if.out_of_range  = cal_res.oor;
      end
      CMD_TO_DC: begin
        out_if.day_time_out = dc_res.day_time;
        out_if.out_of_range = dc_res.oor;
      end
      default: begin
        out_if.out_of_range = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/jcdc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jcdc_checker
// Port-level checks of the converter, attached to the top level by bind.
// ============================================================================
module jcdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] day_time_out,
  input logic [17:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_out,
  input logic [4:0]  hour_out,
  input logic [5:0]  minute_out,
  input logic [25:0] second_us_out,
  input logic        out_of_range
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(day_time_out) && $stable(year_out))
    else $error("stalled result changed");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> day_time_out == 64'd0 && year_out == 18'd0 &&
      month_out == 4'd0 && day_out == 5'd0 && hour_out == 5'd0 &&
      minute_out == 6'd0 && second_us_out == 26'd0)
    else $error("out of range result not cleared");

  a_cal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && month_out != 4'd0 |-> day_time_out == 64'd0 && month_out <= 4'd12 &&
      day_out != 5'd0 && hour_out <= 5'd23 && minute_out <= 6'd59)
    else $error("calendar result malformed");

endmodule

bind julian_calendar_date_converter_core jcdc_checker u_jcdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .day_time_out  (out_if.day_time_out),
  .year_out      (out_if.year_out),
  .month_out     (out_if.month_out),
  .day_out       (out_if.day_out),
  .hour_out      (out_if.hour_out),
  .minute_out    (out_if.minute_out),
  .second_us_out (out_if.second_us_out),
  .out_of_range  (out_if.out_of_range)
);
